// ===== rtl/lfo_amplitude_modulator_unit_macros.svh =====
// Assertion macros shared by the tremolo RTL; they expect i_clk and i_rst_n in scope.
`ifndef LFO_AMPLITUDE_MODULATOR_UNIT_MACROS_SVH
`define LFO_AMPLITUDE_MODULATOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LFOAM_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LFOAM_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lfoam_pkg.sv =====
// Package with the types, constants and sine quarter table of the tremolo block.
`timescale 1ns / 1ps

package lfoam_pkg;

    // Sizing of the block.
    localparam int CHANNELS        = 2;
    localparam int SINE_TABLE_BITS = 10;
    localparam int QUARTER_BITS    = SINE_TABLE_BITS - 2;
    localparam int QUARTER_DEPTH   = 1 << QUARTER_BITS;
    localparam int CH_W            = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Field widths.
    localparam int SAMPLE_W = 24;
    localparam int PHASE_W  = 32;
    localparam int COUNT_W  = 18;
    localparam int WAVE_W   = 19;
    localparam int MAG_W    = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Fixed-point constants.
    localparam logic [MAG_W-1:0] ONE_Q17     = MAG_W'(131072);
    localparam logic [63:0]      ONE_Q30     = 64'd1073741824;
    localparam logic [COUNT_W-1:0] SPS_RESET = COUNT_W'(48000);

    // Odd polynomial coefficients of the quarter sine, Q30.
    localparam logic [4:0][63:0] SINE_COEF = {
        64'd1686629713, 64'd693598677, 64'd85569306, 64'd5026994, 64'd172272
    };

    typedef logic [CH_W-1:0]              t_ch;
    typedef logic signed [WAVE_W-1:0]     t_wave;
    typedef logic [QUARTER_DEPTH-1:0][MAG_W-1:0] t_qtable;

    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_TRIANGLE = 2'd1,
        WAVE_SAW      = 2'd2,
        WAVE_SQUARE   = 2'd3
    } t_wave_sel;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WAVE_SELECT     = 2'd0,
        CFG_PHASE_INCREMENT = 2'd1,
        CFG_SAMPLES_PER_SEC = 2'd2
    } t_cfg_index;

    typedef struct packed {
        t_wave_sel             wave_select;
        logic [PHASE_W-1:0]    phase_increment;
        logic [COUNT_W-1:0]    samples_per_second;
    } t_cfg;

    // sin(pi/2 * x) for x in Q30, rounded to Q1.17 and clamped to one.
    function automatic logic [MAG_W-1:0] quarter_entry(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        int k;
        x2 = (x * x) >> 30;
        t  = SINE_COEF[0];
        for (k = 1; k < 5; k++) begin
            t = SINE_COEF[k] - ((x2 * t) >> 30);
        end
        s = (((x * t) >> 30) + 64'd4096) >> 13;
        if (s > 64'(ONE_Q17)) begin
            s = 64'(ONE_Q17);
        end
        return s[MAG_W-1:0];
    endfunction

    // First quadrant of the sine table, built at elaboration.
    function automatic t_qtable build_quarter_table();
        t_qtable tab;
        int r;
        for (r = 0; r < QUARTER_DEPTH; r++) begin
            tab[r] = quarter_entry(64'(r) << (32 - SINE_TABLE_BITS));
        end
        return tab;
    endfunction

    localparam t_qtable          QUARTER_TABLE = build_quarter_table();
    // Entry at the very top of the quadrant, which the table itself does not hold.
    localparam logic [MAG_W-1:0] QUARTER_TOP   = quarter_entry(ONE_Q30);

endpackage

// ===== rtl/lfoam_if.sv =====
// Interfaces for the configuration, input and result channels of the tremolo block.
`timescale 1ns / 1ps

interface lfoam_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [lfoam_pkg::CFG_IDX_W-1:0]       index;
    logic [lfoam_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface lfoam_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  channel;
    logic signed [lfoam_pkg::SAMPLE_W-1:0] sample_in;

    modport source (output valid, output channel, output sample_in, input ready);
    modport sink   (input valid, input channel, input sample_in, output ready);
endinterface

interface lfoam_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [lfoam_pkg::SAMPLE_W-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

// ===== rtl/lfo_amplitude_modulator_unit.sv =====
// Top level of the tremolo block: LFO amplitude modulation of a two-channel sample stream.
//
// Channels: i_cfg writes a register (0 wave select, 1 phase increment, 2 samples per
// second) whenever valid is high; it is always ready. i_in carries one item, a channel
// index and a signed Q1.23 sample; o_out returns the modulated Q1.23 sample.
// An accepted item passes through the input, wave and result registers in turn before
// it is presented on o_out. Throughput: one item per cycle while o_out.ready is high;
// the only per-item loop is the channel's phase and counter update, an add to each and a
// compare, done as the item leaves the input register.
// Results leave in the order their items arrived.
// Reset: synchronous, active low; it clears every channel's counter and phase, empties
// all three pipeline registers and loads the register defaults (sine, zero increment,
// 48000 samples per second). There is no clearing pass; items may follow at once.
// Stall: while o_out.ready is low the result register holds, and the wave and input
// registers keep filling; i_in.ready drops only when all three are occupied.
`timescale 1ns / 1ps

`include "lfo_amplitude_modulator_unit_macros.svh"

module lfo_amplitude_modulator_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lfoam_cfg_if.sink     i_cfg,
    lfoam_in_if.sink      i_in,
    lfoam_out_if.source   o_out
);

    lfoam_pkg::t_cfg w_cfg;

    logic                                  r_a_valid;
    logic                                  r_a_channel;
    logic signed [lfoam_pkg::SAMPLE_W-1:0] r_a_sample;
    logic                                  r_b_valid;
    logic signed [lfoam_pkg::SAMPLE_W-1:0] r_b_sample;
    lfoam_pkg::t_wave                      r_b_wave;
    logic                                  r_out_valid;
    logic signed [lfoam_pkg::SAMPLE_W-1:0] r_out_sample;

    logic                                  w_a_adv;
    logic                                  w_b_adv;
    lfoam_pkg::t_wave                      w_wave;
    logic signed [lfoam_pkg::SAMPLE_W-1:0] w_scaled;

    // Configuration registers.
    lfoam_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    // Pipeline flow control: a stage moves on when the next one is empty or moving.
    assign w_b_adv    = r_b_valid && (!r_out_valid || o_out.ready);
    assign w_a_adv    = r_a_valid && (!r_b_valid || w_b_adv);
    assign i_in.ready = !r_a_valid || w_a_adv;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_a_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_a_channel <= i_in.channel;
            r_a_sample  <= i_in.sample_in;
        end
    end

    // LFO state and wave value for the item in the input register.
    lfoam_lfo u_lfo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_adv     (w_a_adv),
        .i_channel (r_a_channel),
        .o_wave    (w_wave)
    );

    // Wave register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (!r_b_valid || w_b_adv) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_adv) begin
            r_b_sample <= r_a_sample;
            r_b_wave   <= w_wave;
        end
    end

    // Scaling of the sample by the wave.
    lfoam_scale u_scale (
        .i_sample (r_b_sample),
        .i_wave   (r_b_wave),
        .o_sample (w_scaled)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || o_out.ready) begin
            r_out_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_adv) begin
            r_out_sample <= w_scaled;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out_sample;

    // An item blocked in the input register stays there unchanged.
    `LFOAM_NEXT(a_input_kept, r_a_valid && !w_a_adv, r_a_valid && $stable(r_a_sample) && $stable(r_a_channel), "input item lost while blocked")
    // An item blocked in the wave register keeps its wave value.
    `LFOAM_NEXT(a_wave_kept, r_b_valid && !w_b_adv, r_b_valid && $stable(r_b_wave) && $stable(r_b_sample), "wave item lost while blocked")
    // The wave register only moves on into a free or draining result register.
    `LFOAM_HOLDS(a_no_overrun, w_b_adv && r_out_valid, o_out.ready, "result overwritten before it was taken")

endmodule

// ===== rtl/lfoam_cfg_regs.sv =====
// Configuration registers of the tremolo block.
`timescale 1ns / 1ps

module lfoam_cfg_regs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    lfoam_cfg_if.sink       i_cfg,
    output lfoam_pkg::t_cfg o_cfg
);

    lfoam_pkg::t_cfg r_cfg;
    lfoam_pkg::t_cfg n_cfg;

    // Writes are always taken.
    assign i_cfg.ready = 1'b1;

    // Register decode; an index beyond the list is ignored.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                lfoam_pkg::CFG_WAVE_SELECT: begin
                    n_cfg.wave_select = lfoam_pkg::t_wave_sel'(i_cfg.data[1:0]);
                end
                lfoam_pkg::CFG_PHASE_INCREMENT: begin
                    n_cfg.phase_increment = i_cfg.data[lfoam_pkg::PHASE_W-1:0];
                end
                lfoam_pkg::CFG_SAMPLES_PER_SEC: begin
                    n_cfg.samples_per_second = i_cfg.data[lfoam_pkg::COUNT_W-1:0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wave_select        <= lfoam_pkg::WAVE_SINE;
            r_cfg.phase_increment    <= '0;
            r_cfg.samples_per_second <= lfoam_pkg::SPS_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/lfoam_lfo.sv =====
// Per-channel LFO: sample counter, phase accumulator and wave shaping.
`timescale 1ns / 1ps

`include "lfo_amplitude_modulator_unit_macros.svh"

module lfoam_lfo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lfoam_pkg::t_cfg  i_cfg,
    input  logic             i_adv,
    input  logic             i_channel,
    output lfoam_pkg::t_wave o_wave
);

    logic [lfoam_pkg::CHANNELS-1:0][lfoam_pkg::PHASE_W-1:0] r_phase;
    logic [lfoam_pkg::CHANNELS-1:0][lfoam_pkg::PHASE_W-1:0] n_phase;
    logic [lfoam_pkg::CHANNELS-1:0][lfoam_pkg::COUNT_W-1:0] r_count;
    logic [lfoam_pkg::CHANNELS-1:0][lfoam_pkg::COUNT_W-1:0] n_count;

    lfoam_pkg::t_ch                     w_ch;
    logic [lfoam_pkg::PHASE_W-1:0]      w_phase;
    logic [lfoam_pkg::COUNT_W-1:0]      w_count_inc;
    logic                               w_wrap;
    logic [1:0]                         w_quad;
    logic [lfoam_pkg::QUARTER_BITS-1:0] w_rem;
    logic [lfoam_pkg::MAG_W-1:0]        w_mag;
    logic [lfoam_pkg::MAG_W:0]          w_sine_sum;
    logic signed [lfoam_pkg::WAVE_W:0]  w_tri_q;
    logic signed [lfoam_pkg::WAVE_W:0]  w_tri;

    // A single-channel build folds every channel index onto the one state slot.
    assign w_ch    = (lfoam_pkg::CHANNELS > 1) ? lfoam_pkg::t_ch'(i_channel) : '0;
    assign w_phase = r_phase[w_ch];

    // Counter and phase update; both return to zero once a second has been counted.
    assign w_count_inc = r_count[w_ch] + 1'b1;
    assign w_wrap      = (w_count_inc >= i_cfg.samples_per_second);

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        if (i_adv) begin
            if (w_wrap) begin
                n_phase[w_ch] = '0;
                n_count[w_ch] = '0;
            end else begin
                n_phase[w_ch] = w_phase + i_cfg.phase_increment;
                n_count[w_ch] = w_count_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    // Sine magnitude from the quarter table, mirrored in the second and fourth quadrants.
    assign w_quad = w_phase[lfoam_pkg::PHASE_W-1 -: 2];
    assign w_rem  = w_phase[lfoam_pkg::PHASE_W-3 -: lfoam_pkg::QUARTER_BITS];

    always_comb begin
        if (!w_quad[0]) begin
            w_mag = lfoam_pkg::QUARTER_TABLE[w_rem];
        end else if (w_rem == '0) begin
            w_mag = lfoam_pkg::QUARTER_TOP;
        end else begin
            w_mag = lfoam_pkg::QUARTER_TABLE[~w_rem + 1'b1];
        end
    end

    // Unipolar sine: one half plus half the signed table value.
    always_comb begin
        if (w_quad[1]) begin
            w_sine_sum = {1'b0, lfoam_pkg::ONE_Q17} - {1'b0, w_mag};
        end else begin
            w_sine_sum = {1'b0, lfoam_pkg::ONE_Q17} + {1'b0, w_mag};
        end
    end

    // Bipolar triangle from the top nineteen phase bits.
    assign w_tri_q = $signed({1'b0, w_phase[lfoam_pkg::PHASE_W-1 -: lfoam_pkg::WAVE_W]});

    always_comb begin
        if (w_phase[31:30] == 2'b00) begin
            w_tri = w_tri_q;
        end else if (w_phase[31:30] != 2'b11) begin
            w_tri = 20'sd262144 - w_tri_q;
        end else begin
            w_tri = w_tri_q - 20'sd524288;
        end
    end

    // Wave selection.
    always_comb begin
        unique case (i_cfg.wave_select)
            lfoam_pkg::WAVE_SINE: begin
                o_wave = $signed({1'b0, w_sine_sum[lfoam_pkg::MAG_W:1]});
            end
            lfoam_pkg::WAVE_TRIANGLE: begin
                o_wave = w_tri[lfoam_pkg::WAVE_W-1:0];
            end
            lfoam_pkg::WAVE_SAW: begin
                o_wave = $signed({2'b00, w_phase[lfoam_pkg::PHASE_W-1 -: 17]});
            end
            lfoam_pkg::WAVE_SQUARE: begin
                o_wave = w_phase[31] ? '0 : $signed({1'b0, lfoam_pkg::ONE_Q17});
            end
            default: begin
                o_wave = '0;
            end
        endcase
    end

    // A channel that reaches its limit starts again from zero phase and count.
    `LFOAM_NEXT(a_wrap_clears, i_adv && w_wrap, (r_phase[$past(w_ch)] == '0) && (r_count[$past(w_ch)] == '0), "wrap did not clear channel state")
    // Without an advancing item the channel state does not move.
    `LFOAM_NEXT(a_state_holds, !i_adv, $stable(r_phase) && $stable(r_count), "LFO state changed without an item")
    // The wave never leaves the range of plus or minus one.
    `LFOAM_HOLDS(a_wave_range, i_adv, (o_wave <= 19'sd131072) && (o_wave >= -19'sd131072), "wave value out of range")

endmodule

// ===== rtl/lfoam_scale.sv =====
// Multiplier with round-to-nearest and 24-bit saturation for the tremolo block.
`timescale 1ns / 1ps

module lfoam_scale (
    input  logic signed [lfoam_pkg::SAMPLE_W-1:0] i_sample,
    input  lfoam_pkg::t_wave                      i_wave,
    output logic signed [lfoam_pkg::SAMPLE_W-1:0] o_sample
);

    localparam int PROD_W = lfoam_pkg::SAMPLE_W + lfoam_pkg::WAVE_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int Y_W    = SUM_W - 17;

    logic signed [PROD_W-1:0] w_prod;
    logic signed [SUM_W-1:0]  w_round;
    logic signed [Y_W-1:0]    w_y;

    // Product in Q3.40; add one half of the Q1.23 result step, then floor.
    assign w_prod  = PROD_W'(i_sample) * PROD_W'(i_wave);
    assign w_round = SUM_W'(w_prod) + SUM_W'(65536);
    assign w_y     = w_round[SUM_W-1:17];

    // Saturate to the sample range.
    always_comb begin
        if (w_y > Y_W'(signed'(8388607))) begin
            o_sample = 24'sd8388607;
        end else if (w_y < -Y_W'(signed'(8388608))) begin
            o_sample = -24'sd8388608;
        end else begin
            o_sample = w_y[lfoam_pkg::SAMPLE_W-1:0];
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the tremolo LFO amplitude modulator, with scoreboard and stimulus.
`timescale 1ns / 1ps

// Predicts sample_out for every accepted item and checks the block's results in order.
class tremolo_scoreboard;
    lfoam_pkg::t_wave_sel wave_sel;
    logic [31:0]        step;
    logic [17:0]        rate;
    logic [17:0]        count [2];
    logic [31:0]        phase [2];
    int                 sine_level_tab [1024];
    logic signed [23:0] awaited_out [$];
    int                 errors;

    function new();
        longint unsigned poly [5];
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        logic [9:0]      idx;
        int              i;
        int              k;
        poly[0] = 64'd172272;
        poly[1] = 64'd5026994;
        poly[2] = 64'd85569306;
        poly[3] = 64'd693598677;
        poly[4] = 64'd1686629713;
        // Full-cycle sine in Q1.17, built from an odd polynomial over one quadrant.
        for (i = 0; i < 1024; i++) begin
            idx = i[9:0];
            x = longint'(idx[7:0]) << 22;
            if (idx[8]) begin
                x = 64'd1073741824 - x;
            end
            x2 = (x * x) >> 30;
            t = poly[0];
            for (k = 1; k < 5; k++) begin
                t = poly[k] - ((x2 * t) >> 30);
            end
            s = (((x * t) >> 30) + 64'd4096) >> 13;
            if (s > 64'd131072) begin
                s = 64'd131072;
            end
            sine_level_tab[i] = idx[9] ? -int'(s) : int'(s);
        end
        // Register defaults and per-channel state after reset.
        wave_sel = lfoam_pkg::WAVE_SINE;
        step     = '0;
        rate     = 18'd48000;
        count    = '{default: '0};
        phase    = '{default: '0};
        errors   = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] d);
        case (idx)
            lfoam_pkg::CFG_WAVE_SELECT: begin
                wave_sel = lfoam_pkg::t_wave_sel'(d[1:0]);
            end
            lfoam_pkg::CFG_PHASE_INCREMENT: begin
                step = d;
            end
            lfoam_pkg::CFG_SAMPLES_PER_SEC: begin
                rate = d[17:0];
            end
            default: begin
                // Writes to an index outside the register map are dropped.
            end
        endcase
    endfunction

    // LFO level in Q1.17 for the selected wave at phase p.
    function int lfo_level(logic [31:0] p);
        int q;
        q = int'(p >> 13);
        case (wave_sel)
            lfoam_pkg::WAVE_SINE: begin
                return (131072 + sine_level_tab[p[31:22]]) / 2;
            end
            lfoam_pkg::WAVE_TRIANGLE: begin
                if (p < 32'h4000_0000) begin
                    return q;
                end
                if (p < 32'hC000_0000) begin
                    return 262144 - q;
                end
                return q - 524288;
            end
            lfoam_pkg::WAVE_SAW: begin
                return int'(p >> 15);
            end
            default: begin
                return p[31] ? 0 : 131072;
            end
        endcase
    endfunction

    function void note_sample(logic ch, logic signed [23:0] smp);
        longint prod;
        // Round half up by flooring after adding half an LSB, then saturate.
        prod = (longint'(smp) * lfo_level(phase[ch]) + 65536) >>> 17;
        if (prod > 8388607) begin
            prod = 8388607;
        end else if (prod < -8388608) begin
            prod = -8388608;
        end
        awaited_out.push_back(prod[23:0]);
        // Advance the channel; a full second of samples resets counter and phase.
        phase[ch] = phase[ch] + step;
        count[ch] = count[ch] + 18'd1;
        if (count[ch] >= rate) begin
            count[ch] = '0;
            phase[ch] = '0;
        end
    endfunction

    function void check_result(logic signed [23:0] got);
        logic signed [23:0] want;
        if (awaited_out.size() == 0) begin
            errors++;
            $display("%0t: sample_out expected none, got %0d", $time, got);
            return;
        end
        want = awaited_out.pop_front();
        if (got !== want) begin
            errors++;
            $display("%0t: sample_out expected %0d, got %0d", $time, want, got);
        end
    endfunction
endclass

module tb_top;

    typedef enum {PACE_FULL, PACE_SEND_GAPS, PACE_SINK_STALLS, PACE_BOTH} t_pace;

    localparam logic [1:0] CFG_SPARE     = 2'd3;
    localparam int         QUIET_LIMIT   = 3000;
    localparam int         ITEMS_PER_RUN = 250;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    t_pace             pace = PACE_FULL;
    tremolo_scoreboard sb;

    lfoam_cfg_if cfg_if ();
    lfoam_in_if  in_if ();
    lfoam_out_if out_if ();

    lfo_amplitude_modulator_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Clock with a 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Result sink: stalls at random according to the current pace.
    initial begin
        int stall;
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            stall = (pace == PACE_SINK_STALLS) ? 81 : (pace == PACE_BOTH) ? 16 : 0;
            out_if.ready <= ($urandom_range(0, 99) >= stall);
        end
    end

    // Observe every handshake and feed the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                sb.write_reg(cfg_if.index, cfg_if.data);
            end
            if (in_if.valid && in_if.ready) begin
                sb.note_sample(in_if.channel, in_if.sample_in);
            end
            if (out_if.valid && out_if.ready) begin
                sb.check_result(out_if.sample_out);
            end
        end
    end

    // Ends the run if no handshake of any kind happens for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((cfg_if.valid && cfg_if.ready) || (in_if.valid && in_if.ready) ||
                (out_if.valid && out_if.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // Send one item, with random gaps before it when the pace asks for them.
    task automatic push_sample(input logic ch, input logic signed [23:0] smp);
        int gap;
        gap = (pace == PACE_SEND_GAPS) ? 81 : (pace == PACE_BOTH) ? 16 : 0;
        while ($urandom_range(0, 99) < gap) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.channel   <= ch;
        in_if.sample_in <= smp;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    // Program all registers, after a spare-index write if asked; unused upper bits are random.
    task automatic load_settings(input lfoam_pkg::t_wave_sel wave, input logic [31:0] incr,
                                 input logic [17:0] sps, input bit poke_spare);
        logic [1:0]  idx [$];
        logic [31:0] val [$];
        if (poke_spare) begin
            idx.push_back(CFG_SPARE);
            val.push_back($urandom);
        end
        idx.push_back(lfoam_pkg::CFG_WAVE_SELECT);
        val.push_back({30'($urandom), wave});
        idx.push_back(lfoam_pkg::CFG_PHASE_INCREMENT);
        val.push_back(incr);
        idx.push_back(lfoam_pkg::CFG_SAMPLES_PER_SEC);
        val.push_back({14'($urandom), sps});
        foreach (idx[n]) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= idx[n];
            cfg_if.data  <= val[n];
            do @(posedge i_clk); while (!cfg_if.ready);
        end
        cfg_if.valid <= 1'b0;
    endtask

    // Stop sending and wait until every expected result has come back. The first check
    // follows a wait on the clock, so that the last item sent has been noted by the scoreboard.
    task automatic drain();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.awaited_out.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        logic signed [23:0] corner [5];
        logic signed [23:0] smp;
        logic [31:0]        incr;
        logic [17:0]        sps;
        int                 ph;
        int                 n;
        corner = '{24'sh7FFFFF, 24'sh800000, 24'sh000000, 24'shFFFFFF, 24'sh000001};
        sb = new();
        i_rst_n          = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = '0;
        cfg_if.data      = '0;
        in_if.valid      = 1'b0;
        in_if.channel    = 1'b0;
        in_if.sample_in  = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero sample rate: phase resets after every sample, square passes samples through.
        load_settings(lfoam_pkg::WAVE_SQUARE, 32'h4000_0000, 18'd0, 1'b1);
        for (n = 0; n < 5; n++) begin
            push_sample(n[0], corner[n]);
        end
        drain();

        // Triangle over a whole cycle; full negative sample at the trough saturates.
        load_settings(lfoam_pkg::WAVE_TRIANGLE, 32'h2000_0000, 18'h3FFFF, 1'b0);
        for (n = 0; n < 8; n++) begin
            push_sample(1'b0, n[0] ? corner[0] : corner[1]);
        end
        push_sample(1'b1, corner[0]);
        drain();

        // Rate lowered below the running counter, with a decrementing phase.
        load_settings(lfoam_pkg::WAVE_SAW, 32'hFFFF_FFFF, 18'd5, 1'b0);
        for (n = 0; n < 6; n++) begin
            push_sample(1'b0, corner[0]);
        end
        drain();

        // Sine through all four quadrants.
        load_settings(lfoam_pkg::WAVE_SINE, 32'h3000_0000, 18'h3FFFF, 1'b0);
        for (n = 0; n < 5; n++) begin
            push_sample(1'b1, corner[0]);
        end
        drain();

        // Random runs, each with its own settings and pace.
        for (ph = 0; ph < 8; ph++) begin
            pace = t_pace'(ph % 4);
            case (ph)
                0: begin
                    incr = $urandom;
                    sps  = 18'($urandom_range(1, 300));
                end
                1: begin
                    incr = 32'hFFFF_FFFF;
                    sps  = 18'h3FFFF;
                end
                2: begin
                    incr = $urandom_range(0, 32'h00FF_FFFF);
                    sps  = 18'($urandom_range(1, 300));
                end
                3: begin
                    incr = $urandom;
                    sps  = 18'd1;
                end
                4: begin
                    incr = 32'd0;
                    sps  = 18'($urandom_range(2, 50));
                end
                5: begin
                    incr = $urandom;
                    sps  = 18'd0;
                end
                6: begin
                    incr = $urandom | 32'h8000_0000;
                    sps  = 18'($urandom_range(1, 300));
                end
                default: begin
                    incr = $urandom;
                    sps  = 18'($urandom_range(300, 3000));
                end
            endcase
            load_settings(lfoam_pkg::t_wave_sel'((ph + ph / 4) % 4), incr, sps,
                          (ph % 3) == 0);
            for (n = 0; n < ITEMS_PER_RUN; n++) begin
                if ($urandom_range(0, 9) == 0) begin
                    smp = corner[$urandom_range(0, 4)];
                end else begin
                    smp = 24'($urandom);
                end
                push_sample(1'($urandom), smp);
            end
            drain();
        end

        if (sb.errors == 0 && sb.awaited_out.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0t: %0d mismatches, %0d results outstanding", $time, sb.errors,
                     sb.awaited_out.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
